@@ hw/rtl/lka_pkg.sv @@
// shared constants, codes, types and helpers of the keyframe animator
package lka_pkg;

	localparam int MAX_FRAMES_DEF = 16;

	localparam int FUNC_W     = 2;
	localparam int INDEX_W    = 4;
	localparam int STEP_W     = 15;
	localparam int LEVEL_W    = 8;
	localparam int MODE_W     = 3;
	localparam int FIU_W      = 5;
	localparam int CNT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;
	localparam int NUM_W      = LEVEL_W + STEP_W;
	localparam int DEN_W      = STEP_W;

	localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ON     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MANUAL = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ANIM   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_INTERP = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MODE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_LEVEL  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_STEPS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_OUTPUT = 3'd4;

	localparam logic [LEVEL_W-1:0]      LEVEL_FULL = 8'd255;
	localparam logic signed [CNT_W-1:0] CNT_TOP    = 16'sh7FFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_NEXT_RD,
		ST_MUL,
		ST_DSTART,
		ST_DIV,
		ST_EMIT
	} lka_state_t;

	typedef struct packed {
		logic accept;
		logic rd_search;
		logic compare;
		logic rd_next;
		logic mul;
		logic div_start;
		logic finish;
		logic emit;
	} lka_cmd_t;

	typedef struct packed {
		logic search;
		logic hit;
		logic idx_zero;
		logic interp;
		logic trivial;
		logic div_done;
		logic out_free;
	} lka_status_t;

	// pwm level, or active-low pin level
	function automatic logic [LEVEL_W-1:0] pin_value(input logic [LEVEL_W-1:0] level,
							 input logic analog);
		logic [LEVEL_W-1:0] res;
		if (analog) begin
			res = level;
		end else begin
			res = {{(LEVEL_W-1){1'b0}}, (level == '0)};
		end
		return res;
	endfunction

endpackage

@@ hw/rtl/lka_if.sv @@
// handshake interfaces for the command and drive channels

interface lka_cmd_if;
	import lka_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [INDEX_W-1:0]   frame_index;
	logic [STEP_W-1:0]    frame_step;
	logic [LEVEL_W-1:0]   frame_level;

	modport source (output valid, output func, output frame_index, output frame_step,
			output frame_level, input ready);
	modport sink (input valid, input func, input frame_index, input frame_step,
		      input frame_level, output ready);
endinterface

interface lka_drive_if;
	import lka_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 drive_valid;
	logic [LEVEL_W-1:0]   drive_value;
	logic                 sequence_ended;

	modport source (output valid, output drive_valid, output drive_value,
			output sequence_ended, input ready);
	modport sink (input valid, input drive_valid, input drive_value,
		      input sequence_ended, output ready);
endinterface

@@ hw/rtl/lka_div.sv @@
// restoring divider, one quotient bit a cycle, low quotient byte kept
module lka_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lka_pkg::NUM_W-1:0]  num,
	input  logic [lka_pkg::DEN_W-1:0]  den,
	output logic                       busy,
	output logic [lka_pkg::LEVEL_W-1:0] quot
);
	import lka_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [LEVEL_W-1:0] quot_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic [DEN_W:0]     trial;
	logic               fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			rem_q  <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quot_q <= {quot_q[LEVEL_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

@@ hw/rtl/lka_dp.sv @@
// datapath: registers, keyframe memory, counter, interpolation arithmetic
module lka_dp #(
	parameter int MAX_FRAMES = lka_pkg::MAX_FRAMES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lka_pkg::lka_cmd_t              ctl,
	output lka_pkg::lka_status_t           sts,
	input  logic [lka_pkg::FUNC_W-1:0]     func,
	input  logic [lka_pkg::INDEX_W-1:0]    frame_index,
	input  logic [lka_pkg::STEP_W-1:0]     frame_step,
	input  logic [lka_pkg::LEVEL_W-1:0]    frame_level,
	input  logic                           cfg_write,
	input  logic [lka_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lka_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           drive_valid,
	output logic [lka_pkg::LEVEL_W-1:0]    drive_value,
	output logic                           sequence_ended
);
	import lka_pkg::*;

	localparam int FI_W  = $clog2(MAX_FRAMES);
	localparam int XW    = (FI_W > INDEX_W) ? FI_W : INDEX_W;
	localparam int ENT_W = STEP_W + LEVEL_W;

	// configuration registers
	logic [MODE_W-1:0]  mode_cfg_q;
	logic [LEVEL_W-1:0] manual_cfg_q;
	logic [STEP_W-1:0]  hold_q;
	logic [FIU_W-1:0]   fiu_q;
	logic               analog_q;

	// run state
	logic signed [CNT_W-1:0] cnt_q;
	logic                    pending_q;
	logic [MODE_W-1:0]       run_mode_q;
	logic [LEVEL_W-1:0]      run_level_q;

	// search and interpolation
	logic [ENT_W-1:0]   mem [MAX_FRAMES];
	logic [ENT_W-1:0]   rdata_q;
	logic [FI_W-1:0]    idx_q;
	logic [FI_W-1:0]    f_q;
	logic [LEVEL_W-1:0] fv_q;
	logic [STEP_W-1:0]  fs_q;
	logic               trivial_q;
	logic               q_neg_q;
	logic [NUM_W-1:0]   prod_q;
	logic [DEN_W-1:0]   den_q;

	// result held until the output register is free
	logic               res_valid_q;
	logic [LEVEL_W-1:0] res_value_q;
	logic               res_ended_q;

	logic               out_valid_q;
	logic               out_dv_q;
	logic [LEVEL_W-1:0] out_value_q;
	logic               out_ended_q;

	logic [XW-1:0]           idx_x;
	logic [FI_W-1:0]         wr_addr;
	logic                    wr_en;
	logic [FI_W-1:0]         rd_addr;
	logic [FI_W-1:0]         last_idx;
	logic [FI_W-1:0]         nx;
	logic signed [CNT_W-1:0] cnt_inc;
	logic signed [CNT_W-1:0] cnt_restart;
	logic [LEVEL_W-1:0]      fixed_level;
	logic [STEP_W-1:0]       rstep;
	logic [LEVEL_W-1:0]      rlevel;
	logic                    hit;
	logic [LEVEL_W-1:0]      dv_mag;
	logic [STEP_W-1:0]       dc;
	logic [NUM_W-1:0]        prod_c;
	logic [LEVEL_W-1:0]      quot;
	logic [LEVEL_W-1:0]      q_signed;
	logic [LEVEL_W-1:0]      interp_level;
	logic                    div_busy;
	logic                    fixed_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cfg_q   <= MODE_OFF;
			manual_cfg_q <= '0;
			hold_q       <= '0;
			fiu_q        <= FIU_W'(1);
			analog_q     <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LIGHT_MODE:    mode_cfg_q   <= cfg_data[MODE_W-1:0];
				CFG_MANUAL_LEVEL:  manual_cfg_q <= cfg_data[LEVEL_W-1:0];
				CFG_HOLD_STEPS:    hold_q       <= cfg_data[STEP_W-1:0];
				CFG_FRAMES_IN_USE: fiu_q        <= cfg_data[FIU_W-1:0];
				CFG_ANALOG_OUTPUT: analog_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// frame count clamped to 1..MAX_FRAMES, as a last index
	always_comb begin
		if (fiu_q == '0) begin
			last_idx = '0;
		end else if (32'(fiu_q) > MAX_FRAMES) begin
			last_idx = FI_W'(MAX_FRAMES - 1);
		end else begin
			last_idx = FI_W'(fiu_q - FIU_W'(1));
		end
	end

	assign fixed_run   = run_mode_q <= MODE_MANUAL;
	assign cnt_inc     = (cnt_q != CNT_TOP) ? cnt_q + 16'sd1 : cnt_q;
	assign cnt_restart = (mode_cfg_q <= MODE_MANUAL) ? -$signed({1'b0, hold_q}) : '0;

	always_comb begin
		case (run_mode_q)
			MODE_OFF: fixed_level = '0;
			MODE_ON:  fixed_level = LEVEL_FULL;
			default:  fixed_level = run_level_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pending_q   <= 1'b0;
			run_mode_q  <= MODE_OFF;
			run_level_q <= '0;
		end else if (ctl.accept) begin
			case (func)
				FUNC_RESTART: begin
					run_mode_q  <= mode_cfg_q;
					run_level_q <= manual_cfg_q;
					pending_q   <= 1'b1;
					cnt_q       <= cnt_restart;
				end
				FUNC_TICK: begin
					cnt_q <= cnt_inc;
					if (fixed_run) begin
						pending_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// keyframe memory, one write and one registered read a cycle
	assign idx_x   = XW'(frame_index);
	assign wr_addr = idx_x[FI_W-1:0];
	assign wr_en   = ctl.accept && (func == FUNC_LOAD) && (32'(frame_index) < MAX_FRAMES);
	assign nx      = (f_q != last_idx) ? f_q + FI_W'(1) : f_q;
	assign rd_addr = ctl.rd_next ? nx : idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {frame_step, frame_level};
		end
		if (ctl.rd_search || ctl.rd_next) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rstep  = rdata_q[ENT_W-1:LEVEL_W];
	assign rlevel = rdata_q[LEVEL_W-1:0];
	assign hit    = cnt_q >= $signed({1'b0, rstep});

	// magnitudes for the interpolation quotient
	assign dv_mag = (rlevel >= fv_q) ? rlevel - fv_q : fv_q - rlevel;
	assign dc     = cnt_q[STEP_W-1:0] - fs_q;
	assign prod_c = NUM_W'(dv_mag) * NUM_W'(dc);

	assign q_signed     = q_neg_q ? LEVEL_W'(-quot) : quot;
	assign interp_level = trivial_q ? fv_q : fv_q + q_signed;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			idx_q       <= last_idx;
			res_valid_q <= 1'b0;
			res_value_q <= '0;
			res_ended_q <= 1'b0;
			if (func == FUNC_TICK && fixed_run) begin
				if (pending_q) begin
					res_valid_q <= 1'b1;
					res_value_q <= pin_value(fixed_level, analog_q);
				end else if (cnt_inc == '0) begin
					res_ended_q <= 1'b1;
				end
			end
		end
		if (ctl.compare) begin
			if (hit) begin
				f_q         <= idx_q;
				fv_q        <= rlevel;
				fs_q        <= rstep;
				res_valid_q <= 1'b1;
				res_ended_q <= idx_q == last_idx;
				res_value_q <= pin_value(rlevel, analog_q);
			end else if (idx_q != '0) begin
				idx_q <= idx_q - FI_W'(1);
			end
		end
		if (ctl.mul) begin
			trivial_q <= (rlevel == fv_q) || (rstep == fs_q);
			q_neg_q   <= (rlevel < fv_q) ^ (rstep < fs_q);
			prod_q    <= prod_c;
			den_q     <= (rstep >= fs_q) ? rstep - fs_q : fs_q - rstep;
		end
		if (ctl.finish) begin
			res_value_q <= pin_value(interp_level, analog_q);
		end
	end

	lka_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (prod_q),
		.den    (den_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			out_dv_q    <= res_valid_q;
			out_value_q <= res_value_q;
			out_ended_q <= res_ended_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_valid    = out_dv_q;
	assign drive_value    = out_value_q;
	assign sequence_ended = out_ended_q;

	assign sts.search   = (func == FUNC_TICK)
			      && (run_mode_q == MODE_ANIM || run_mode_q == MODE_INTERP);
	assign sts.hit      = hit;
	assign sts.idx_zero = idx_q == '0;
	assign sts.interp   = run_mode_q == MODE_INTERP;
	assign sts.trivial  = trivial_q;
	assign sts.div_done = !div_busy;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

@@ hw/rtl/lka_ctrl.sv @@
// controller state machine sequencing search, interpolation and output
module lka_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lka_pkg::lka_status_t sts,
	output lka_pkg::lka_cmd_t    ctl
);
	import lka_pkg::*;

	lka_state_t state_q;
	lka_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_nxt  = sts.search ? ST_SRCH_RD : ST_EMIT;
				end
			end
			ST_SRCH_RD: begin
				ctl.rd_search = 1'b1;
				state_nxt     = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				ctl.compare = 1'b1;
				if (sts.hit) begin
					state_nxt = sts.interp ? ST_NEXT_RD : ST_EMIT;
				end else if (sts.idx_zero) begin
					state_nxt = ST_EMIT;
				end else begin
					state_nxt = ST_SRCH_RD;
				end
			end
			ST_NEXT_RD: begin
				ctl.rd_next = 1'b1;
				state_nxt   = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul   = 1'b1;
				state_nxt = ST_DSTART;
			end
			ST_DSTART: begin
				if (sts.trivial) begin
					ctl.finish = 1'b1;
					state_nxt  = ST_EMIT;
				end else begin
					ctl.div_start = 1'b1;
					state_nxt     = ST_DIV;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					ctl.finish = 1'b1;
					state_nxt  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					ctl.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/led_keyframe_animator.sv @@
// top level of the led keyframe animator
//
// channel   | role  | word carries
// ----------+-------+-----------------------------------------------------
// cmd       | sink  | func, frame_index, frame_step, frame_level
// drive     | src   | drive_valid, drive_value, sequence_ended
// cfg_*     | write | cfg_index selects register, cfg_data the value
//
// one word is worked at a time; ready is high only in the idle state
// load, restart and tick in off/on/manual: idle, then emit into the output register
// animate tick: a registered memory read and a compare per keyframe probed, then emit
// interpolate adds next read, multiply, divider start; bit-serial divider when needed
// reset clears the counter, flags and run mode; the keyframe memory is not cleared
// a finished word waits in the output register, the next command is taken meanwhile
module led_keyframe_animator #(
	parameter int MAX_FRAMES = lka_pkg::MAX_FRAMES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lka_cmd_if.sink                        cmd,
	lka_drive_if.source                    drive,
	input  logic                           cfg_write,
	input  logic [lka_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lka_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lka_pkg::*;

	lka_cmd_t    ctl;
	lka_status_t sts;

	// sequencer: owns the handshake on the command side
	lka_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// datapath: config, counter, keyframe memory, divider, output register
	lka_dp #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.sts            (sts),
		.func           (cmd.func),
		.frame_index    (cmd.frame_index),
		.frame_step     (cmd.frame_step),
		.frame_level    (cmd.frame_level),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (drive.valid),
		.out_ready      (drive.ready),
		.drive_valid    (drive.drive_valid),
		.drive_value    (drive.drive_value),
		.sequence_ended (drive.sequence_ended)
	);

endmodule

@@ hw/rtl/lka_checker.sv @@
// port-level checks on the keyframe animator, bound to the top level
module lka_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         drive_valid,
	input logic [lka_pkg::LEVEL_W-1:0]  drive_value,
	input logic                         sequence_ended
);
	import lka_pkg::*;

	// a held word stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("drive word dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable(drive_valid) && $stable(drive_value) && $stable(sequence_ended))
		else $error("drive word changed while stalled");

	// no drive means a zero level
	a_idle_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_valid |-> drive_value == '0)
		else $error("drive value set without drive_valid");

	// one command at a time: taking a word leaves the idle state
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("command taken on back-to-back cycles");

endmodule

bind led_keyframe_animator lka_checker u_lka_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (cmd.valid),
	.in_ready       (cmd.ready),
	.out_valid      (drive.valid),
	.out_ready      (drive.ready),
	.drive_valid    (drive.drive_valid),
	.drive_value    (drive.drive_value),
	.sequence_ended (drive.sequence_ended)
);

@@ sim/led_keyframe_animator_test.sv @@
// self-checking testbench of the led keyframe animator: directed table and random phases
module led_keyframe_animator_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lka_pkg::*;

	// codes the package leaves out: the spare func code and a reserved light mode
	localparam logic [FUNC_W-1:0] FUNC_UNUSED   = 2'd3;
	localparam logic [MODE_W-1:0] MODE_RESERVED = 3'd7;

	// no new random phase starts once this many words (spare func aside) have gone in
	localparam int RANDOM_WORDS = 1200;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [INDEX_W-1:0] frame_index;
		logic [STEP_W-1:0]  frame_step;
		logic [LEVEL_W-1:0] frame_level;
	} cmd_word_t;

	typedef struct packed {
		logic               drive_valid;
		logic [LEVEL_W-1:0] drive_value;
		logic               sequence_ended;
	} drive_word_t;

	typedef enum logic {
		ROW_REG,
		ROW_WORD
	} row_kind_t;

	// one line of the directed table: a register write or a command word,
	// the latter with its result typed in when fixed is set
	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		cmd_word_t             word;
		logic                  fixed;
		drive_word_t           want;
	} plan_row_t;

	localparam cmd_word_t   TICK     = '{FUNC_TICK, 4'd0, 15'd0, 8'd0};
	localparam cmd_word_t   RESTART  = '{FUNC_RESTART, 4'd0, 15'd0, 8'd0};
	localparam cmd_word_t   SPARE    = '{FUNC_UNUSED, 4'd0, 15'd0, 8'd0};
	localparam drive_word_t NO_DRIVE = '{1'b0, 8'd0, 1'b0};

	localparam int PLAN_ROWS = 39;

	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// straight out of reset: off mode, nothing pending
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, NO_DRIVE},
		// spare func code changes nothing
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, SPARE, 1'b1, NO_DRIVE},
		// off with zero hold: drive 0 once, counter already past 0
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, RESTART, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, '{1'b1, 8'd0, 1'b0}},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, NO_DRIVE},
		// on, digital pin, hold of three ticks: pin low, then end flag
		'{ROW_REG, CFG_LIGHT_MODE, 15'(MODE_ON), TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_HOLD_STEPS, 15'd3, TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_ANALOG_OUTPUT, 15'd0, TICK, 1'b0, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, RESTART, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, '{1'b1, 8'd0, 1'b0}},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, '{1'b0, 8'd0, 1'b1}},
		// manual at full level, longest hold
		'{ROW_REG, CFG_LIGHT_MODE, 15'(MODE_MANUAL), TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_MANUAL_LEVEL, 15'd255, TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_ANALOG_OUTPUT, 15'd1, TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_HOLD_STEPS, 15'd32767, TICK, 1'b0, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, RESTART, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, '{1'b1, 8'd255, 1'b0}},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, NO_DRIVE},
		// manual at zero on the digital pin: pin goes high
		'{ROW_REG, CFG_MANUAL_LEVEL, 15'd0, TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_ANALOG_OUTPUT, 15'd0, TICK, 1'b0, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, RESTART, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, '{1'b1, 8'd1, 1'b0}},
		// reserved mode: counter only
		'{ROW_REG, CFG_LIGHT_MODE, 15'(MODE_RESERVED), TICK, 1'b0, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, RESTART, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, NO_DRIVE},
		// keyframe extremes in the first and last slot
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, '{FUNC_LOAD, 4'd0, 15'd0, 8'd0}, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, '{FUNC_LOAD, 4'd15, 15'd32767, 8'd255}, 1'b1,
		  NO_DRIVE},
		// animate with frame count 0, clamped to a single frame: it is also the last
		'{ROW_REG, CFG_LIGHT_MODE, 15'(MODE_ANIM), TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_FRAMES_IN_USE, 15'd0, TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_ANALOG_OUTPUT, 15'd1, TICK, 1'b0, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, RESTART, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b1, '{1'b1, 8'd0, 1'b1}},
		// interpolate with frame count 31, clamped to all sixteen
		'{ROW_REG, CFG_LIGHT_MODE, 15'(MODE_INTERP), TICK, 1'b0, NO_DRIVE},
		'{ROW_REG, CFG_FRAMES_IN_USE, 15'd31, TICK, 1'b0, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, RESTART, 1'b1, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b0, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b0, NO_DRIVE},
		'{ROW_WORD, CFG_LIGHT_MODE, 15'd0, TICK, 1'b0, NO_DRIVE}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lka_cmd_if   cmd_ch ();
	lka_drive_if drive_ch ();

	led_keyframe_animator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.drive     (drive_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// register shadow, as written
	logic [MODE_W-1:0]  reg_mode   = MODE_OFF;
	logic [LEVEL_W-1:0] reg_manual = '0;
	logic [STEP_W-1:0]  reg_hold   = '0;
	logic [FIU_W-1:0]   reg_frames = 5'd1;
	logic               reg_analog = 1'b1;

	// animator state as the predictor sees it
	int                 step_count  = 0;
	bit                 change_flag = 1'b0;
	logic [MODE_W-1:0]  run_mode    = MODE_OFF;
	logic [LEVEL_W-1:0] run_level   = '0;
	logic [STEP_W-1:0]  key_step  [MAX_FRAMES_DEF];
	logic [LEVEL_W-1:0] key_level [MAX_FRAMES_DEF];

	drive_word_t pending_drives [$];
	int          mismatches     = 0;
	int          words_sent     = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous ceiling: the slowest legal run is a few ms
	initial begin
		#30_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// pwm level as is, or the active-low pin: high only for a dark led
	function automatic logic [LEVEL_W-1:0] pin_level(input logic [LEVEL_W-1:0] lvl);
		if (reg_analog)
			return lvl;
		return (lvl == '0) ? 8'd1 : 8'd0;
	endfunction

	// straight line from frame f toward the next one, truncating toward zero;
	// the last frame has no successor and holds its own level
	function automatic logic [LEVEL_W-1:0] lerp_level(input int f, input int n);
		int nx;
		int fv;
		int tv;
		int fs;
		int ts;
		int q;
		nx = (f != n - 1) ? f + 1 : f;
		fv = int'(key_level[f]);
		tv = int'(key_level[nx]);
		fs = int'(key_step[f]);
		ts = int'(key_step[nx]);
		if (fv == tv || ts == fs)
			return key_level[f];
		q = ((tv - fv) * (step_count - fs)) / (ts - fs);
		// out-of-order frames can overshoot: keep the low byte
		return 8'(fv + q);
	endfunction

	// advance the animator state by one command word, return the drive word it yields
	function automatic drive_word_t next_drive(input cmd_word_t w);
		drive_word_t        d;
		int                 n;
		logic [LEVEL_W-1:0] lvl;
		d = NO_DRIVE;
		case (w.func)
			FUNC_LOAD: begin
				key_step[w.frame_index]  = w.frame_step;
				key_level[w.frame_index] = w.frame_level;
			end
			FUNC_RESTART: begin
				// mode and manual level are only picked up here
				run_mode    = reg_mode;
				run_level   = reg_manual;
				change_flag = 1'b1;
				step_count  = (reg_mode <= MODE_MANUAL) ? -int'(reg_hold) : 0;
			end
			FUNC_TICK: begin
				if (step_count < int'(CNT_TOP))
					step_count++;
				if (run_mode <= MODE_MANUAL) begin
					if (change_flag) begin
						change_flag = 1'b0;
						d.drive_valid = 1'b1;
						d.drive_value = pin_level(run_mode == MODE_OFF ? 8'd0 :
									  run_mode == MODE_ON ? LEVEL_FULL :
									  run_level);
					end else if (step_count == 0) begin
						d.sequence_ended = 1'b1;
					end
				end else if (run_mode <= MODE_INTERP) begin
					n = int'(reg_frames);
					if (n < 1)
						n = 1;
					if (n > MAX_FRAMES_DEF)
						n = MAX_FRAMES_DEF;
					// latest frame already reached wins; none reached gives nothing
					for (int f = n - 1; f >= 0; f--) begin
						if (step_count >= int'(key_step[f])) begin
							lvl = (run_mode == MODE_INTERP) ? lerp_level(f, n)
											: key_level[f];
							d.drive_valid    = 1'b1;
							d.drive_value    = pin_level(lvl);
							d.sequence_ended = (f == n - 1);
							break;
						end
					end
				end
			end
			default: ;
		endcase
		return d;
	endfunction

	task automatic set_idling(input int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
			default: begin send_idle_pct = 7; recv_stall_pct = 7; end
		endcase
	endtask

	// present one word, wait for it to be taken, then log what it should produce;
	// valid stays high on return so back-to-back words need no second assignment
	task automatic send_word(input cmd_word_t w, input logic fixed = 1'b0,
				 input drive_word_t want = NO_DRIVE);
		drive_word_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.func        <= w.func;
		cmd_ch.frame_index <= w.frame_index;
		cmd_ch.frame_step  <= w.frame_step;
		cmd_ch.frame_level <= w.frame_level;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		predicted = next_drive(w);
		pending_drives.push_back(fixed ? want : predicted);
		if (w.func != FUNC_UNUSED)
			words_sent++;
	endtask

	// every item yields one word, so an empty queue means the block is idle
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_drives.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
				 input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			CFG_LIGHT_MODE:    reg_mode   = data[MODE_W-1:0];
			CFG_MANUAL_LEVEL:  reg_manual = data[LEVEL_W-1:0];
			CFG_HOLD_STEPS:    reg_hold   = data[STEP_W-1:0];
			CFG_FRAMES_IN_USE: reg_frames = data[FIU_W-1:0];
			CFG_ANALOG_OUTPUT: reg_analog = data[0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// fill all sixteen slots: ascending steps with small gaps (repeats allowed),
	// or random steps; dark and full levels come up often
	task automatic load_frame_set(input bit sorted);
		cmd_word_t   w;
		int unsigned at;
		at = sorted ? $urandom_range(4) : 0;
		for (int k = 0; k < MAX_FRAMES_DEF; k++) begin
			w.func        = FUNC_LOAD;
			w.frame_index = 4'(k);
			w.frame_step  = sorted ? 15'(at) : 15'($urandom_range(70));
			if ($urandom_range(7) == 0)
				w.frame_level = 8'd0;
			else if ($urandom_range(7) == 0)
				w.frame_level = LEVEL_FULL;
			else
				w.frame_level = 8'($urandom_range(255));
			send_word(w);
			at += $urandom_range(4);
		end
	endtask

	// one random phase: fresh registers, maybe fresh frames, a restart and a run
	// of ticks with some stray loads, spare codes and restarts mixed in
	task automatic random_phase(input int phase);
		int                r;
		int                count;
		logic [MODE_W-1:0] mode;
		cmd_word_t         w;
		wait_idle();
		set_idling(phase);
		r = $urandom_range(99);
		if (r < 12)
			mode = MODE_OFF;
		else if (r < 24)
			mode = MODE_ON;
		else if (r < 36)
			mode = MODE_MANUAL;
		else if (r < 66)
			mode = MODE_ANIM;
		else if (r < 94)
			mode = MODE_INTERP;
		else
			mode = 3'($urandom_range(7, 5));
		write_reg(CFG_LIGHT_MODE, 15'(mode));
		if ($urandom_range(3) == 0)
			write_reg(CFG_MANUAL_LEVEL, $urandom_range(1) ? 15'd255 : 15'd0);
		else
			write_reg(CFG_MANUAL_LEVEL, 15'($urandom_range(255)));
		r = $urandom_range(99);
		if (r < 10)
			write_reg(CFG_HOLD_STEPS, 15'd32767);
		else if (r < 15)
			write_reg(CFG_HOLD_STEPS, 15'($urandom_range(32767)));
		else
			write_reg(CFG_HOLD_STEPS, 15'($urandom_range(30)));
		r = $urandom_range(99);
		if (r < 5)
			write_reg(CFG_FRAMES_IN_USE, 15'd0);
		else if (r < 10)
			write_reg(CFG_FRAMES_IN_USE, 15'($urandom_range(31, 17)));
		else
			write_reg(CFG_FRAMES_IN_USE, 15'($urandom_range(16, 1)));
		write_reg(CFG_ANALOG_OUTPUT, 15'($urandom_range(1)));
		end_writes();
		// the first phase always loads fresh frames, later phases only sometimes
		if (phase == 0 || $urandom_range(1) == 1)
			load_frame_set($urandom_range(4) != 0);
		send_word(RESTART);
		count = $urandom_range(80, 10);
		repeat (count) begin
			// payload bits of ticks and spare codes are junk the block must ignore
			w.frame_index = 4'($urandom_range(15));
			w.frame_step  = 15'($urandom_range(32767));
			w.frame_level = 8'($urandom_range(255));
			r = $urandom_range(99);
			if (r < 6)
				w.func = FUNC_LOAD;
			else if (r < 9)
				w.func = FUNC_UNUSED;
			else if (r < 12)
				w.func = FUNC_RESTART;
			else
				w.func = FUNC_TICK;
			send_word(w);
		end
	endtask

	// drive channel: random back-pressure, every word taken is checked against
	// the oldest expectation
	initial begin : drive_check
		drive_word_t want;
		drive_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1) begin
				if (pending_drives.size() == 0) begin
					mismatches++;
					$display("%0t: drive word with none expected: valid %b value %0d end %b",
						 $time, drive_ch.drive_valid, drive_ch.drive_value,
						 drive_ch.sequence_ended);
				end else begin
					want = pending_drives.pop_front();
					if (drive_ch.drive_valid !== want.drive_valid) begin
						mismatches++;
						$display("%0t: drive_valid expected %b, got %b", $time,
							 want.drive_valid, drive_ch.drive_valid);
					end
					if (drive_ch.drive_value !== want.drive_value) begin
						mismatches++;
						$display("%0t: drive_value expected %0d, got %0d", $time,
							 want.drive_value, drive_ch.drive_value);
					end
					if (drive_ch.sequence_ended !== want.sequence_ended) begin
						mismatches++;
						$display("%0t: sequence_ended expected %b, got %b", $time,
							 want.sequence_ended, drive_ch.sequence_ended);
					end
				end
			end
			drive_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin : stimulus
		bit writing;
		writing            = 1'b0;
		arst_n             = 1'b0;
		cfg_write          = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.func        = FUNC_TICK;
		cmd_ch.frame_index = '0;
		cmd_ch.frame_step  = '0;
		cmd_ch.frame_level = '0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		set_idling(0);

		// the keyframe store powers up unknown: fill every slot before any search
		load_frame_set(1'b1);

		// directed table; register rows wait for the block to go quiet first
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_REG) begin
				if (!writing)
					wait_idle();
				writing = 1'b1;
				write_reg(PLAN[i].reg_index, PLAN[i].reg_value);
			end else begin
				if (writing)
					end_writes();
				writing = 1'b0;
				send_word(PLAN[i].word, PLAN[i].fixed, PLAN[i].want);
			end
		end

		// random phases, cycling through the idling patterns
		words_sent = 0;
		for (int p = 0; words_sent < RANDOM_WORDS; p++)
			random_phase(p);

		wait_idle();
		// a quiet tail so that a stray extra word would still be seen
		repeat (100)
			@(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/lka_pkg.sv
hw/rtl/lka_if.sv
hw/rtl/lka_div.sv
hw/rtl/lka_dp.sv
hw/rtl/lka_ctrl.sv
hw/rtl/led_keyframe_animator.sv
hw/rtl/lka_checker.sv
sim/led_keyframe_animator_test.sv
